FILE: hdl/rkc98_pkg.sv
// ----------------------------------------------------------------------------
// rkc98_pkg
// Shared types and constants for the 98-symbol running-key cipher core.
// ----------------------------------------------------------------------------
package rkc98_pkg;

  localparam int BOOK_DEPTH_DEF = 4096;
  localparam int KEY_W          = 16;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_ENC  = 2'd1;
  localparam logic [1:0] MODE_DEC  = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BLANK = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_BAD   = 3'd4;

  localparam logic [8:0] ALPHABET     = 9'd98;
  localparam logic [8:0] ALPHABET_X2  = 9'd196;
  localparam logic [6:0] SYM_TAB      = 7'd96;
  localparam logic [6:0] SYM_NEWLINE  = 7'd97;
  localparam logic [7:0] PRINT_OFFSET = 8'd31;
  localparam logic [7:0] CHR_TAB      = 8'd9;
  localparam logic [7:0] CHR_NEWLINE  = 8'd10;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] in_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_value;
    logic [2:0] status;
  } out_item_t;

endpackage

FILE: hdl/rkc98_key_mod.sv
// ----------------------------------------------------------------------------
// rkc98_key_mod
// Bit-serial remainder of the 16-bit key by the book length, one key bit
// per cycle (restoring division, quotient discarded).
// ----------------------------------------------------------------------------
module rkc98_key_mod
  import rkc98_pkg::*;
#(
  parameter int CNT_W = $clog2(BOOK_DEPTH_DEF + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [CNT_W-1:0] remainder
);

  localparam int STEP_W = $clog2(KEY_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    key_nxt  = key_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, key_r[KEY_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      key_nxt  = key;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = CNT_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = CNT_W'(trial);
      end
      key_nxt  = {key_r[KEY_W-2:0], 1'b0};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(KEY_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    key_r <= key_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

FILE: hdl/running_key_cipher_98_core.sv
// ----------------------------------------------------------------------------
// running_key_cipher_98_core
// Running-key book cipher over a 98-symbol alphabet.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready beats of {mode, in_byte, last}. Mode 0 appends a book
//           byte, mode 1 encrypts a byte, mode 2 decrypts a symbol. last ends
//           the book or message.
//   out_* : valid/ready beats of {out_value, status}, one per input beat.
//   cfg_* : valid/ready write of agent_key; write only while the core idles.
// Flow, one item at a time:
//   load items and rejected items: result appears in the cycle after the input beat.
//   message items: book memory read, then combine.
//   first message item after last: the bit-serial key-modulo-length
//   unit (16 steps) runs ahead of the memory read.
// The next beat is taken when the core is idle and the output register is
// empty or being drained in the same cycle; a stalled receiver holds the
// result and blocks input. Reset (rst_n, synchronous) empties the book,
// clears the key and arms a fresh start; book memory contents are not
// cleared, only entries below the book count are ever read.
// ----------------------------------------------------------------------------
module running_key_cipher_98_core
  import rkc98_pkg::*;
#(
  parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [KEY_W-1:0] cfg_data
);

  localparam int POS_W = $clog2(BOOK_DEPTH);
  localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_READ, S_CALC} state_t;

  state_t           state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;
  logic [CNT_W-1:0] book_count_r, book_count_nxt;
  logic [POS_W-1:0] book_pos_r, book_pos_nxt;
  logic             fresh_r, fresh_nxt;
  logic [KEY_W-1:0] agent_key_r;
  logic             enc_r, enc_nxt;
  logic             last_r, last_nxt;
  logic [6:0]       sym_r, sym_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic [6:0]       book_mem [BOOK_DEPTH];
  logic [6:0]       rd_data_r;
  logic             mem_we;

  logic             in_fire, out_fire;
  logic [CNT_W-1:0] eff_count;
  logic             is_blank;
  logic [6:0]       in_sym;
  logic             sym_ok;
  logic             div_start, div_done;
  logic [CNT_W-1:0] div_rem;
  logic [8:0]       sum_raw, sum_mod;
  logic [6:0]       v;
  logic [7:0]       calc_value;
  logic [CNT_W-1:0] pos_inc;

  rkc98_key_mod #(.CNT_W(CNT_W)) u_key_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .key       (agent_key_r),
    .divisor   (book_count_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a load after last starts a new book
  assign eff_count = fresh_r ? '0 : book_count_r;
  assign is_blank  = (in_item.in_byte == 8'd32) ||
                     (in_item.in_byte >= 8'd9 && in_item.in_byte <= 8'd13);

  always_comb begin
    in_sym = '0;
    sym_ok = 1'b1;
    if (in_item.mode == MODE_ENC) begin
      if (in_item.in_byte == CHR_TAB) begin
        in_sym = SYM_TAB;
      end else if (in_item.in_byte == CHR_NEWLINE) begin
        in_sym = SYM_NEWLINE;
      end else if (in_item.in_byte >= 8'd32 && in_item.in_byte <= 8'd126) begin
        in_sym = 7'(in_item.in_byte - PRINT_OFFSET);
      end else begin
        sym_ok = 1'b0;
      end
    end else begin
      in_sym = in_item.in_byte[6:0];
      sym_ok = ({1'b0, in_item.in_byte} < ALPHABET);
    end
  end

  // combine symbol with book byte, reduce modulo 98 (sum stays below 3 * 98)
  always_comb begin
    if (enc_r) begin
      sum_raw = {2'b00, sym_r} + {2'b00, rd_data_r};
    end else begin
      sum_raw = {2'b00, sym_r} + ALPHABET_X2 - {2'b00, rd_data_r};
    end
    if (sum_raw >= ALPHABET_X2) begin
      sum_mod = sum_raw - ALPHABET_X2;
    end else if (sum_raw >= ALPHABET) begin
      sum_mod = sum_raw - ALPHABET;
    end else begin
      sum_mod = sum_raw;
    end
    v = sum_mod[6:0];
    if (enc_r) begin
      calc_value = {1'b0, v};
    end else if (v == SYM_TAB) begin
      calc_value = CHR_TAB;
    end else if (v == SYM_NEWLINE) begin
      calc_value = CHR_NEWLINE;
    end else begin
      calc_value = {1'b0, v} + PRINT_OFFSET;
    end
    pos_inc = CNT_W'(pos_r) + 1'b1;
  end

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    book_count_nxt = book_count_r;
    book_pos_nxt   = book_pos_r;
    fresh_nxt      = fresh_r;
    enc_nxt        = enc_r;
    last_nxt       = last_r;
    sym_nxt        = sym_r;
    pos_nxt        = pos_r;
    mem_we         = 1'b0;
    div_start      = 1'b0;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_item.mode) inside
            MODE_LOAD: begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{out_value: 8'd0, status: ST_OK};
              fresh_nxt     = in_item.last;
              if (fresh_r) begin
                book_count_nxt = '0;
                book_pos_nxt   = '0;
              end
              if (is_blank) begin
                out_item_nxt.status = ST_BLANK;
              end else if (in_item.in_byte[7]) begin
                out_item_nxt.status = ST_BAD;
              end else if (eff_count == CNT_W'(BOOK_DEPTH)) begin
                out_item_nxt.status = ST_FULL;
              end else begin
                mem_we         = 1'b1;
                book_count_nxt = eff_count + 1'b1;
              end
            end
            MODE_ENC, MODE_DEC: begin
              fresh_nxt = in_item.last;
              if (book_count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{out_value: 8'd0, status: ST_EMPTY};
              end else if (!sym_ok) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{out_value: 8'd0, status: ST_BAD};
              end else begin
                enc_nxt  = (in_item.mode == MODE_ENC);
                last_nxt = in_item.last;
                sym_nxt  = in_sym;
                // fresh_start is committed only when the item completes
                fresh_nxt = fresh_r;
                if (fresh_r) begin
                  div_start = 1'b1;
                  state_nxt = S_DIV;
                end else begin
                  pos_nxt   = (CNT_W'(book_pos_r) >= book_count_r) ? '0 : book_pos_r;
                  state_nxt = S_READ;
                end
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{out_value: 8'd0, status: ST_BAD};
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          pos_nxt   = div_rem[POS_W-1:0];
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CALC;
      end
      S_CALC: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{out_value: calc_value, status: ST_OK};
        book_pos_nxt  = (pos_inc >= book_count_r) ? '0 : pos_inc[POS_W-1:0];
        fresh_nxt     = last_r;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      book_count_r <= '0;
      book_pos_r   <= '0;
      fresh_r      <= 1'b1;
      agent_key_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      book_count_r <= book_count_nxt;
      book_pos_r   <= book_pos_nxt;
      fresh_r      <= fresh_nxt;
      if (cfg_valid && cfg_ready) begin
        agent_key_r <= cfg_data;
      end
    end
    out_item_r <= out_item_nxt;
    enc_r      <= enc_nxt;
    last_r     <= last_nxt;
    sym_r      <= sym_nxt;
    pos_r      <= pos_nxt;
  end

  // book memory: one write port (loads), one registered read port (messages)
  always_ff @(posedge clk) begin
    if (mem_we) begin
      book_mem[eff_count[POS_W-1:0]] <= in_item.in_byte[6:0];
    end
    rd_data_r <= book_mem[pos_r];
  end

endmodule
